FILE: rtl/serial_command_deframer_macros.svh
// ---------------------------------------------------------------------------
// serial_command_deframer_macros.svh
// Assertion macros shared by the deframer RTL. All of them sample on aclk and
// are disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_DEFRAMER_MACROS_SVH
`define SERIAL_COMMAND_DEFRAMER_MACROS_SVH

// Property that must hold at every clock edge.
`define SCD_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define SCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/scd_pkg.sv
// ---------------------------------------------------------------------------
// scd_pkg
// Types, framing constants and the control program of the serial command
// deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

    localparam logic [7:0] START_MARK   = 8'h3A;  // ':'
    localparam logic [7:0] END_MARK     = 8'h23;  // '#'
    localparam logic [7:0] BINARY_FLOOR = 8'hA0;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int TEXT_LEN_W  = 6;
    localparam int PC_W        = 5;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TEXT  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TAKE,
        OP_STORE,
        OP_ADVANCE,
        OP_OPEN,
        OP_ERROR,
        OP_TEXT,
        OP_EMIT_INIT,
        OP_CAP_ADDR,
        OP_CAP_REG,
        OP_CAP_DATA,
        OP_PUT_REC,
        OP_CLOSE
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_WORD,
        C_HUNTING,
        C_FULL,
        C_TEXT_END,
        C_NO_REC_END,
        C_BYTE_END,
        C_NOT_START,
        C_OUT_BUSY,
        C_ADDR_ODD,
        C_MORE_RECS
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } uop_t;

    // Step addresses of the control program.
    localparam logic [PC_W-1:0] S_WAIT        = 5'd0;
    localparam logic [PC_W-1:0] S_IF_HUNT     = 5'd1;
    localparam logic [PC_W-1:0] S_IF_FULL     = 5'd2;
    localparam logic [PC_W-1:0] S_STORE       = 5'd3;
    localparam logic [PC_W-1:0] S_IF_TEXT_END = 5'd4;
    localparam logic [PC_W-1:0] S_IF_MID_REC  = 5'd5;
    localparam logic [PC_W-1:0] S_IF_CLOSE    = 5'd6;
    localparam logic [PC_W-1:0] S_ADVANCE     = 5'd7;
    localparam logic [PC_W-1:0] S_HUNT        = 5'd8;
    localparam logic [PC_W-1:0] S_OPEN        = 5'd9;
    localparam logic [PC_W-1:0] S_ERR_WAIT    = 5'd10;
    localparam logic [PC_W-1:0] S_ERR_PUT     = 5'd11;
    localparam logic [PC_W-1:0] S_TXT_WAIT    = 5'd12;
    localparam logic [PC_W-1:0] S_TXT_PUT     = 5'd13;
    localparam logic [PC_W-1:0] S_EMIT_INIT   = 5'd14;
    localparam logic [PC_W-1:0] S_CAP_ADDR    = 5'd15;
    localparam logic [PC_W-1:0] S_CAP_REG     = 5'd16;
    localparam logic [PC_W-1:0] S_CAP_D0      = 5'd17;
    localparam logic [PC_W-1:0] S_CAP_D1      = 5'd18;
    localparam logic [PC_W-1:0] S_CAP_D2      = 5'd19;
    localparam logic [PC_W-1:0] S_CAP_D3      = 5'd20;
    localparam logic [PC_W-1:0] S_REC_WAIT    = 5'd21;
    localparam logic [PC_W-1:0] S_REC_PUT     = 5'd22;
    localparam logic [PC_W-1:0] S_CLOSE       = 5'd23;

    // Control store: a step jumps to target when its condition holds,
    // else falls through to the next step.
    function automatic uop_t ucode_at(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            S_WAIT:        u = '{OP_TAKE,      C_NO_WORD,    S_WAIT};
            S_IF_HUNT:     u = '{OP_NOP,       C_HUNTING,    S_HUNT};
            S_IF_FULL:     u = '{OP_NOP,       C_FULL,       S_ERR_WAIT};
            S_STORE:       u = '{OP_STORE,     C_NEVER,      S_WAIT};
            S_IF_TEXT_END: u = '{OP_NOP,       C_TEXT_END,   S_TXT_WAIT};
            S_IF_MID_REC:  u = '{OP_NOP,       C_NO_REC_END, S_WAIT};
            S_IF_CLOSE:    u = '{OP_NOP,       C_BYTE_END,   S_EMIT_INIT};
            S_ADVANCE:     u = '{OP_ADVANCE,   C_ALWAYS,     S_WAIT};
            S_HUNT:        u = '{OP_NOP,       C_NOT_START,  S_WAIT};
            S_OPEN:        u = '{OP_OPEN,      C_ALWAYS,     S_WAIT};
            S_ERR_WAIT:    u = '{OP_NOP,       C_OUT_BUSY,   S_ERR_WAIT};
            S_ERR_PUT:     u = '{OP_ERROR,     C_ALWAYS,     S_WAIT};
            S_TXT_WAIT:    u = '{OP_NOP,       C_OUT_BUSY,   S_TXT_WAIT};
            S_TXT_PUT:     u = '{OP_TEXT,      C_ALWAYS,     S_WAIT};
            S_EMIT_INIT:   u = '{OP_EMIT_INIT, C_NEVER,      S_WAIT};
            S_CAP_ADDR:    u = '{OP_CAP_ADDR,  C_NEVER,      S_WAIT};
            S_CAP_REG:     u = '{OP_CAP_REG,   C_ADDR_ODD,   S_REC_WAIT};
            S_CAP_D0:      u = '{OP_CAP_DATA,  C_NEVER,      S_WAIT};
            S_CAP_D1:      u = '{OP_CAP_DATA,  C_NEVER,      S_WAIT};
            S_CAP_D2:      u = '{OP_CAP_DATA,  C_NEVER,      S_WAIT};
            S_CAP_D3:      u = '{OP_CAP_DATA,  C_NEVER,      S_WAIT};
            S_REC_WAIT:    u = '{OP_NOP,       C_OUT_BUSY,   S_REC_WAIT};
            S_REC_PUT:     u = '{OP_PUT_REC,   C_MORE_RECS,  S_CAP_ADDR};
            S_CLOSE:       u = '{OP_CLOSE,     C_ALWAYS,     S_WAIT};
            default:       u = '{OP_NOP,       C_ALWAYS,     S_WAIT};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/scd_ram.sv
// ---------------------------------------------------------------------------
// scd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module scd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/serial_command_deframer.sv
// ---------------------------------------------------------------------------
// serial_command_deframer
// Hunts for ':' in a received byte stream and turns each message into text
// results or a burst of binary read/write records.
// ---------------------------------------------------------------------------
// Usage
//   Slave channel (s_t*): one received serial byte per word in s_tdata[7:0].
//   Master channel (m_t*): one result per word; m_tuser carries the kind
//   (read record, write record, text complete, overflow error), m_tlast flags
//   the final result of a message.
//   A small control program steps a plain datapath. After a byte is
//   accepted, s_tready stays low until the program is back at its wait
//   step; a closing '#' starts the record burst, which replays the message
//   buffer through one RAM read port, one result per record, at most 16
//   records. A read record captures address and register; a write record
//   also captures four data bytes. A text or error result is loaded once
//   the byte that causes it is accepted and the output register is free.
//   Results sit in an output register, so the next byte is taken while a
//   result still waits; a further result holds the program until the
//   receiver takes the pending one.
//   Reset (aresetn low, synchronous) returns to hunting with no result
//   pending; the message buffer is not cleared and needs no clearing pass.
//   A byte that arrives when the buffer already holds BUF_LEN bytes is
//   dropped, an error result is sent and the block hunts again.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_command_deframer
    import scd_pkg::*;
#(
    parameter int BUF_LEN = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [7:0] dev_addr, [15:8] reg_index,
                                        // [47:16] data_word, [53:48] text_len,
                                        // [55:54] zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast
);

`include "serial_command_deframer_macros.svh"

    localparam int AW = $clog2(BUF_LEN);
    localparam int LW = $clog2(BUF_LEN + 1);
    localparam int TW = (LW > TEXT_LEN_W) ? LW : TEXT_LEN_W;

    // Sequencer.
    logic [PC_W-1:0]       pc_reg, pc_next;
    uop_t                  uop;
    logic                  cond_true;

    // Receive side.
    logic [7:0]            byte_reg, byte_next;
    logic [LW-1:0]         len_reg, len_next;     // bytes in buffer, 0 = hunting
    logic [LW-1:0]         rs_reg, rs_next;       // index of current record
    logic                  is_text_reg, is_text_next;
    logic                  odd_reg, odd_next;     // current record is a read

    // Replay side.
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [7:0]            rec_addr_reg, rec_addr_next;
    logic [7:0]            rec_idx_reg, rec_idx_next;
    logic [31:0]           rec_data_reg, rec_data_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [7:0]            out_addr_reg, out_addr_next;
    logic [7:0]            out_idx_reg, out_idx_next;
    logic [31:0]           out_data_reg, out_data_next;
    logic [TEXT_LEN_W-1:0] out_tlen_reg, out_tlen_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_busy;
    logic                  out_load;
    logic                  ram_we;
    logic [7:0]            ram_rdata;
    logic                  rec_end;
    logic                  rec_last;
    logic [LW-1:0]         end_idx;
    logic [TW-1:0]         len_wide;
    logic [TEXT_LEN_W-1:0] text_len_sat;

    assign uop = ucode_at(pc_reg);

    // Message buffer; read address follows ptr_next so that ram_rdata always
    // shows the byte at ptr_reg.
    scd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_LEN)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (byte_reg),
        .raddr (ptr_next),
        .rdata (ram_rdata)
    );

    assign out_busy = out_valid_reg && !m_tready;

    // Record complete once its last byte is in: 3 bytes past its start for a
    // read, 7 for a write (address, register, four data bytes, next byte).
    assign rec_end = odd_reg ?
        ({1'b0, len_reg} == ({1'b0, rs_reg} + (LW+1)'(3))) :
        ({1'b0, len_reg} == ({1'b0, rs_reg} + (LW+1)'(7)));

    // Index of the closing '#'; replay stops there or at the result cap.
    assign end_idx  = len_reg - LW'(1);
    assign rec_last = (LW'(ptr_reg) >= end_idx) || (cnt_reg == CNT_W'(MAX_RESULTS - 1));

    assign len_wide     = TW'(len_reg);
    assign text_len_sat = (len_wide > TW'(63)) ? 6'd63 : len_wide[TEXT_LEN_W-1:0];

    always_comb begin
        unique case (uop.cond)
            C_NEVER:      cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_NO_WORD:    cond_true = !s_tvalid;
            C_HUNTING:    cond_true = (len_reg == '0);
            C_FULL:       cond_true = (len_reg >= LW'(BUF_LEN));
            C_TEXT_END:   cond_true = is_text_reg && (byte_reg == END_MARK);
            C_NO_REC_END: cond_true = is_text_reg || !rec_end;
            C_BYTE_END:   cond_true = (byte_reg == END_MARK);
            C_NOT_START:  cond_true = (byte_reg != START_MARK);
            C_OUT_BUSY:   cond_true = out_busy;
            C_ADDR_ODD:   cond_true = rec_addr_reg[0];
            C_MORE_RECS:  cond_true = !rec_last;
            default:      cond_true = 1'b0;
        endcase
    end

    assign pc_next  = cond_true ? uop.target : pc_reg + PC_W'(1);
    assign s_tready = (uop.op == OP_TAKE);
    assign out_load = (uop.op == OP_ERROR) || (uop.op == OP_TEXT) || (uop.op == OP_PUT_REC);

    always_comb begin
        byte_next      = byte_reg;
        len_next       = len_reg;
        rs_next        = rs_reg;
        is_text_next   = is_text_reg;
        odd_next       = odd_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        rec_addr_next  = rec_addr_reg;
        rec_idx_next   = rec_idx_reg;
        rec_data_next  = rec_data_reg;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_idx_next   = out_idx_reg;
        out_data_next  = out_data_reg;
        out_tlen_next  = out_tlen_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;

        // Drop the pending result once taken; a load below overrides.
        out_valid_next = out_valid_reg && !m_tready;

        unique case (uop.op)
            OP_NOP: begin
            end
            OP_TAKE: begin
                if (s_tvalid) begin
                    byte_next = s_tdata;
                end
            end
            OP_STORE: begin
                // Append the byte; the first one after ':' picks text or
                // binary, and a byte at the record start is its address.
                ram_we   = 1'b1;
                len_next = len_reg + LW'(1);
                if (len_reg == LW'(1)) begin
                    is_text_next = (byte_reg < BINARY_FLOOR);
                end
                if (len_reg == rs_reg) begin
                    odd_next = byte_reg[0];
                end
            end
            OP_ADVANCE: begin
                // The byte just stored is the address of the next record.
                rs_next  = rs_reg + (odd_reg ? LW'(2) : LW'(6));
                odd_next = byte_reg[0];
            end
            OP_OPEN: begin
                len_next = LW'(1);
                rs_next  = LW'(1);
            end
            OP_ERROR: begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_ERROR;
                out_addr_next  = '0;
                out_idx_next   = '0;
                out_data_next  = '0;
                out_tlen_next  = '0;
                out_last_next  = 1'b1;
                len_next       = '0;
                rs_next        = LW'(1);
            end
            OP_TEXT: begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_TEXT;
                out_addr_next  = '0;
                out_idx_next   = '0;
                out_data_next  = '0;
                out_tlen_next  = text_len_sat;
                out_last_next  = 1'b1;
                len_next       = '0;
            end
            OP_EMIT_INIT: begin
                ptr_next = AW'(1);
                cnt_next = '0;
            end
            OP_CAP_ADDR: begin
                rec_addr_next = ram_rdata;
                rec_data_next = '0;
                ptr_next      = ptr_reg + AW'(1);
            end
            OP_CAP_REG: begin
                rec_idx_next = ram_rdata;
                ptr_next     = ptr_reg + AW'(1);
            end
            OP_CAP_DATA: begin
                // Shift in from the top: the first data byte ends up lowest.
                rec_data_next = {ram_rdata, rec_data_reg[31:8]};
                ptr_next      = ptr_reg + AW'(1);
            end
            OP_PUT_REC: begin
                out_valid_next = 1'b1;
                out_kind_next  = rec_addr_reg[0] ? KIND_READ : KIND_WRITE;
                out_addr_next  = rec_addr_reg;
                out_idx_next   = rec_idx_reg;
                out_data_next  = rec_data_reg;
                out_tlen_next  = '0;
                out_last_next  = rec_last;
                cnt_next       = cnt_reg + CNT_W'(1);
            end
            OP_CLOSE: begin
                len_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= S_WAIT;
            len_reg       <= '0;
            rs_reg        <= LW'(1);
            is_text_reg   <= 1'b0;
            odd_reg       <= 1'b0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            len_reg       <= len_next;
            rs_reg        <= rs_next;
            is_text_reg   <= is_text_next;
            odd_reg       <= odd_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        rec_addr_reg <= rec_addr_next;
        rec_idx_reg  <= rec_idx_next;
        rec_data_reg <= rec_data_next;
        out_kind_reg <= out_kind_next;
        out_addr_reg <= out_addr_next;
        out_idx_reg  <= out_idx_next;
        out_data_reg <= out_data_next;
        out_tlen_reg <= out_tlen_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_tlen_reg, out_data_reg, out_idx_reg, out_addr_reg};

    // Never overwrite a result the receiver has not taken.
    `SCD_ASSERT(a_no_overwrite, !(out_load && out_busy), "result loaded over a pending one")
    // Byte count never passes the buffer size.
    `SCD_ASSERT(a_len_bound, len_reg <= LW'(BUF_LEN), "message length beyond buffer")
    // An accepted byte is always dispatched next.
    `SCD_ASSERT_NXT(a_take_dispatch, s_tvalid && s_tready, pc_reg == S_IF_HUNT,
        "accepted byte not dispatched")
    // Error results always close their run.
    `SCD_ASSERT_IMP(a_err_last, m_tvalid && (m_tuser == KIND_ERROR), m_tlast,
        "error result without last")

endmodule

`default_nettype wire

FILE: test/serial_command_deframer_test.sv
// ----------------------------------------------------------------------------
// serial_command_deframer_test
// Self-checking bench for the serial command deframer. Drives received bytes
// on the slave stream and predicts every text, record and overflow result.
// Both sides stall at random. Each master word is checked field by field
// against the oldest predicted result.
// ----------------------------------------------------------------------------

module serial_command_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scd_pkg::*;

    localparam int BUF_LEN        = 32;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int MAX_GAP        = 16;
    localparam int PAYLOAD_TARGET = 270;   // bytes of framed traffic to send
    localparam int TAIL_CYCLES    = 200;   // idle time left for a stray result
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        kind_t       kind;
        logic [7:0]  dev_addr;
        logic [7:0]  reg_index;
        logic [31:0] data_word;
        logic [5:0]  text_len;
        logic        last;
    } deframer_result_t;

    // Tracks the framing state of the byte stream and queues the results that
    // each accepted byte must produce.
    class deframer_scoreboard;
        logic [7:0]       msg_buf [BUF_LEN];
        int unsigned      msg_len;
        int unsigned      rec_base;
        deframer_result_t awaited [$];
        int unsigned      mismatches;

        function new();
            msg_len    = 0;
            rec_base   = 1;
            mismatches = 0;
        endfunction

        function logic [7:0] byte_at(int unsigned idx);
            return (idx < BUF_LEN) ? msg_buf[idx] : 8'h00;
        endfunction

        function void push_result(kind_t kind, logic [7:0] addr, logic [7:0] index,
                                  logic [31:0] data, int unsigned tlen, logic last);
            deframer_result_t r;
            r.kind      = kind;
            r.dev_addr  = addr;
            r.reg_index = index;
            r.data_word = data;
            r.text_len  = (tlen > 63) ? 6'd63 : 6'(tlen);
            r.last      = last;
            awaited.push_back(r);
        endfunction

        // Walk the buffered message record by record and queue one result each.
        function void replay_records();
            int unsigned pos;
            int unsigned close_pos;
            int unsigned count;
            logic [7:0]  addr;
            pos       = 1;
            close_pos = msg_len - 1;
            count     = 0;
            while (pos < close_pos && count < MAX_RESULTS) begin
                addr = byte_at(pos);
                if (addr[0]) begin
                    push_result(KIND_READ, addr, byte_at(pos + 1), 32'h0, 0, 1'b0);
                    pos += 2;
                end else begin
                    push_result(KIND_WRITE, addr, byte_at(pos + 1),
                                {byte_at(pos + 5), byte_at(pos + 4),
                                 byte_at(pos + 3), byte_at(pos + 2)}, 0, 1'b0);
                    pos += 6;
                end
                count++;
            end
            if (count > 0)
                awaited[awaited.size() - 1].last = 1'b1;
            msg_len = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0] lead;
            if (msg_len == 0) begin
                if (b == START_MARK) begin
                    msg_buf[0] = b;
                    msg_len    = 1;
                    rec_base   = 1;
                end
                return;
            end
            if (msg_len >= BUF_LEN) begin
                // Buffer full: drop the byte, flag overflow, hunt again.
                msg_len  = 0;
                rec_base = 1;
                push_result(KIND_ERROR, 8'h00, 8'h00, 32'h0, 0, 1'b1);
                return;
            end
            msg_buf[msg_len] = b;
            msg_len++;
            if (msg_buf[1] < BINARY_FLOOR) begin
                if (b == END_MARK) begin
                    push_result(KIND_TEXT, 8'h00, 8'h00, 32'h0, msg_len, 1'b1);
                    msg_len = 0;
                end
            end else if (msg_len == rec_base + 3) begin
                lead = byte_at(rec_base);
                if (lead[0]) begin
                    if (byte_at(rec_base + 2) == END_MARK)
                        replay_records();
                    else
                        rec_base += 2;
                end
            end else if (msg_len == rec_base + 7) begin
                lead = byte_at(rec_base);
                if (!lead[0]) begin
                    if (byte_at(rec_base + 6) == END_MARK)
                        replay_records();
                    else
                        rec_base += 6;
                end
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [55:0] data, logic last);
            deframer_result_t want;
            if (awaited.size() == 0) begin
                $error("result with nothing awaited: kind %0d tdata 0x%h last %0b",
                       kind, data, last);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("kind", 32'(want.kind), 32'(kind));
            compare_field("dev_addr", 32'(want.dev_addr), 32'(data[7:0]));
            compare_field("reg_index", 32'(want.reg_index), 32'(data[15:8]));
            compare_field("data_word", want.data_word, data[47:16]);
            compare_field("text_len", 32'(want.text_len), 32'(data[53:48]));
            compare_field("pad", 32'h0, 32'(data[55:54]));
            compare_field("last", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    deframer_scoreboard board = new();

    logic [7:0]  frame_bytes [$];   // bytes of the frame being sent
    bit          sender_calm  = 1'b0;
    int unsigned payload_bytes = 0;
    int unsigned quiet_cycles  = 0;

    serial_command_deframer #(
        .BUF_LEN (BUF_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Any byte except the end mark; used wherever a '#' would close a frame.
    function automatic logic [7:0] not_end_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == END_MARK)
            v = v ^ 8'h01;
        return v;
    endfunction

    // Hold off a random number of cycles, then present one word and wait
    // for the handshake. Keep tvalid high across back-to-back words.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_frame(input bit counted);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        if (counted)
            payload_bytes += frame_bytes.size();
        frame_bytes.delete();
    endtask

    // Drop tvalid and hold until every predicted result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.awaited.size() != 0);
    endtask

    // Sample both channels at the clock edge: feed the predictor with every
    // accepted byte, check every accepted result, and watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                board.check_result(m_tuser, m_tdata, m_tlast);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    // Result receiver: stall a random number of cycles before each word,
    // with calm stretches where tready stays high.
    initial begin : receiver
        int stall;
        bit calm;
        calm = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 29) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int         pick;
        int         limit;
        int         body;
        int         noise_len;
        int         k;
        bit         fill;
        bit         reads_only;
        logic [7:0] addr;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: both noise extremes while hunting, an empty text
        // message, text whose first byte sits just below the binary floor,
        // a read record at the top address followed by a write record at the
        // binary floor whose data holds both marks, and text carrying ':'.
        frame_bytes = {8'h00, 8'hFF,
                       START_MARK, END_MARK,
                       START_MARK, 8'h9F, END_MARK,
                       START_MARK, 8'hFF, 8'h00,
                       8'hA0, 8'hFF, 8'h00, 8'hFF, END_MARK, START_MARK, END_MARK,
                       START_MARK, 8'h41, START_MARK, END_MARK};
        send_frame(1'b1);
        wait_drained();

        // Random part: mostly well-formed frames with random content, plus
        // overflowing frames and raw noise.
        while (payload_bytes < PAYLOAD_TARGET) begin
            if ($urandom_range(0, 9) == 0)
                sender_calm = !sender_calm;
            pick = $urandom_range(0, 99);
            frame_bytes.push_back(START_MARK);
            if (pick < 45) begin
                // Binary records closed by '#'; sometimes fill the buffer.
                fill       = ($urandom_range(0, 4) == 0);
                reads_only = fill && ($urandom_range(0, 1) == 1);
                limit      = fill ? BUF_LEN - 1 : $urandom_range(3, BUF_LEN - 1);
                while (limit - frame_bytes.size() >= 2) begin
                    addr = (frame_bytes.size() == 1) ?
                           8'($urandom_range(BINARY_FLOOR, 255)) : not_end_byte();
                    if (reads_only || limit - frame_bytes.size() < 6)
                        addr[0] = 1'b1;
                    frame_bytes.push_back(addr);
                    frame_bytes.push_back(8'($urandom));
                    if (!addr[0])
                        repeat (4) frame_bytes.push_back(8'($urandom));
                end
                frame_bytes.push_back(END_MARK);
                send_frame(1'b1);
            end else if (pick < 75) begin
                // Text frame; the first byte may itself be the end mark.
                addr = 8'($urandom_range(0, BINARY_FLOOR - 1));
                frame_bytes.push_back(addr);
                if (addr != END_MARK) begin
                    body = ($urandom_range(0, 4) == 0) ? BUF_LEN - 3 : $urandom_range(0, 12);
                    repeat (body)
                        frame_bytes.push_back(($urandom_range(0, 7) == 0) ?
                                              START_MARK : not_end_byte());
                    frame_bytes.push_back(END_MARK);
                end
                send_frame(1'b1);
            end else if (pick < 85) begin
                // Fill the buffer with no close, then one byte too many.
                if ($urandom_range(0, 1) == 0) begin
                    addr = 8'($urandom_range(0, BINARY_FLOOR - 1));
                    frame_bytes.push_back((addr == END_MARK) ? 8'h22 : addr);
                    while (frame_bytes.size() < BUF_LEN)
                        frame_bytes.push_back(not_end_byte());
                end else begin
                    while (frame_bytes.size() < BUF_LEN) begin
                        addr = (frame_bytes.size() == 1) ?
                               8'($urandom_range(BINARY_FLOOR, 255)) : not_end_byte();
                        frame_bytes.push_back(addr);
                        if (frame_bytes.size() < BUF_LEN)
                            frame_bytes.push_back(8'($urandom));
                        for (k = 0; k < 4 && !addr[0] && frame_bytes.size() < BUF_LEN; k++)
                            frame_bytes.push_back(8'($urandom));
                    end
                end
                frame_bytes.push_back(($urandom_range(0, 2) == 0) ?
                                      START_MARK : 8'($urandom));
                send_frame(1'b1);
            end else begin
                // Raw noise, rich in marks; may open or break a frame.
                frame_bytes.delete();
                noise_len = $urandom_range(1, 8);
                repeat (noise_len) begin
                    case ($urandom_range(0, 3))
                        0:       frame_bytes.push_back(START_MARK);
                        1:       frame_bytes.push_back(END_MARK);
                        default: frame_bytes.push_back(8'($urandom));
                    endcase
                end
                send_frame(1'b0);
            end
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end

        // Drain, then give the block time to show any stray result.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.awaited.size() != 0) begin
            $error("%0d predicted results never arrived", board.awaited.size());
            board.mismatches++;
        end
        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
